/* rtl/irrigation_zone_sequencer_unit_macros.svh */
// ----------------------------------------------------------------------------
// Irrigation zone sequencer assertion macros
// Shared concurrent assertion forms used by the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef IRRIGATION_ZONE_SEQUENCER_UNIT_MACROS_SVH
`define IRRIGATION_ZONE_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define IZS_ASSERT_IMP(lbl, clk, rst_n, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("izs: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define IZS_ASSERT_NXT(lbl, clk, rst_n, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("izs: next-cycle check failed");

`endif

/* rtl/izs_pkg.sv */
// ----------------------------------------------------------------------------
// Irrigation zone sequencer package
// Widths, codes, types and shared structs of the sequencer.
// ----------------------------------------------------------------------------
package izs_pkg;

    localparam int MAX_ZONES = 16;
    localparam int ZONE_W    = 5;
    localparam int ADDR_W    = $clog2(MAX_ZONES);
    localparam int MASK_W    = 16;
    localparam int MIN_W     = 11;
    localparam int SEC_W     = 17;
    localparam int ALU_W     = 19;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Seconds per minute as a difference of two shifts: 64 - 4
    localparam int SPM_SHIFT_HI       = 6;
    localparam int SPM_SHIFT_LO       = 2;
    localparam int SECONDS_PER_MINUTE = (1 << SPM_SHIFT_HI) - (1 << SPM_SHIFT_LO);
    localparam int MAX_MIN_INT        = 1440;
    localparam int MAX_SEC_INT        = MAX_MIN_INT * SECONDS_PER_MINUTE;

    typedef logic [ZONE_W-1:0]       t_zone;
    typedef logic [ADDR_W-1:0]       t_addr;
    typedef logic [MASK_W-1:0]       t_valve;
    typedef logic [MIN_W-1:0]        t_min;
    typedef logic [SEC_W-1:0]        t_sec;
    typedef logic signed [ALU_W-1:0] t_alu_val;

    localparam t_min     MAX_MINUTES = t_min'(MAX_MIN_INT);
    localparam t_alu_val MAX_SECONDS = t_alu_val'(MAX_SEC_INT);

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_ZONE    = 2'd1,
        REQ_RTWRITE = 2'd2,
        REQ_RAIN    = 2'd3
    } t_req;

    // Requested run kind codes
    localparam logic [1:0] RUNIN_SINGLE = 2'd0;
    localparam logic [1:0] RUNIN_ALL    = 2'd1;
    localparam logic [1:0] RUNIN_SCHED  = 2'd2;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_SINGLE = 2'd1,
        KIND_ALL    = 2'd2,
        KIND_SCHED  = 2'd3
    } t_run_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZONE_COUNT    = 3'd0,
        CFG_MASTER_ENABLE = 3'd1,
        CFG_CAL_ENABLE    = 3'd2,
        CFG_RAIN_DELAY    = 3'd3,
        CFG_ZONE_MASK     = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ALU_MUL_SPM = 2'd0,
        ALU_SUB     = 2'd1,
        ALU_DEC     = 2'd2
    } t_alu_op;

    typedef struct packed {
        t_alu_op  op;
        t_alu_val a;
        t_alu_val b;
    } t_alu_req;

    typedef struct packed {
        t_alu_val res;
        t_sec     sat;
    } t_alu_rsp;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_min  wdata;
        t_addr raddr;
    } t_mem_ctl;

endpackage

/* rtl/izs_req_if.sv */
// ----------------------------------------------------------------------------
// Irrigation zone sequencer request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface izs_req_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           req_type;
    logic [1:0]           run_kind_in;
    izs_pkg::t_zone       zone_number;
    logic                 turn_on;
    izs_pkg::t_min        run_minutes;
    izs_pkg::t_min        new_runtime;

    modport source (
        output valid, req_type, run_kind_in, zone_number, turn_on,
               run_minutes, new_runtime,
        input  ready
    );

    modport sink (
        input  valid, req_type, run_kind_in, zone_number, turn_on,
               run_minutes, new_runtime,
        output ready
    );
endinterface

/* rtl/izs_rsp_if.sv */
// ----------------------------------------------------------------------------
// Irrigation zone sequencer response channel
// Valid/ready channel carrying one result item with the block status.
// ----------------------------------------------------------------------------
interface izs_rsp_if;
    logic                 valid;
    logic                 ready;
    logic                 accepted;
    izs_pkg::t_valve      valve_bits;
    logic                 master_on;
    izs_pkg::t_zone       active_zone;
    logic [1:0]           active_kind;
    izs_pkg::t_sec        seconds_left;

    modport source (
        output valid, accepted, valve_bits, master_on, active_zone,
               active_kind, seconds_left,
        input  ready
    );

    modport sink (
        input  valid, accepted, valve_bits, master_on, active_zone,
               active_kind, seconds_left,
        output ready
    );
endinterface

/* rtl/irrigation_zone_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// Irrigation zone sequencer
// Valve sequencer for up to sixteen zones plus a master valve.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one item per transaction: a one-second tick, a zone
//   request, a runtime write or a rain-delay event. o_rsp returns exactly
//   one transaction per item: the accepted flag plus valve, master, zone,
//   kind and seconds-left status after the item. Registers are written on
//   i_cfg_we with i_cfg_idx / i_cfg_data; the user must do so only while
//   idle, which the block does not check; indexes past the list are dropped.
// Timing:
//   i_req.ready is high only in the idle state; one item is in flight at a
//   time. After acceptance an item passes S_DECODE, then any of S_TICK,
//   S_EXPIRE, S_SCAN, S_LEN, S_START or S_RW_A..S_RW_D, then S_DONE. An
//   all-zones run scans for its next zone one runtime table entry per cycle
//   through the table's single read port; the seconds arithmetic goes one
//   step a cycle through the shared subtractor.
//   The result sits in an output register, so the next item is taken while
//   a stalled result waits; a new result waits in the done state until the
//   output register is free.
// Reset:
//   Synchronous, active low: all valves off, no run, registers to their
//   defaults, runtime table reads zero for every zone.
// ----------------------------------------------------------------------------
`include "irrigation_zone_sequencer_unit_macros.svh"

module irrigation_zone_sequencer_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    izs_req_if.sink                            i_req,
    izs_rsp_if.source                          o_rsp,
    input  logic                               i_cfg_we,
    input  logic [izs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [izs_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DECODE = 12'b0000_0000_0010,
        S_TICK   = 12'b0000_0000_0100,
        S_EXPIRE = 12'b0000_0000_1000,
        S_SCAN   = 12'b0000_0001_0000,
        S_LEN    = 12'b0000_0010_0000,
        S_START  = 12'b0000_0100_0000,
        S_RW_A   = 12'b0000_1000_0000,
        S_RW_B   = 12'b0001_0000_0000,
        S_RW_C   = 12'b0010_0000_0000,
        S_RW_D   = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } t_state;

    // Zone has a usable output: 1..16 and mask bit set
    function automatic logic f_has_output(input izs_pkg::t_zone z,
                                          input izs_pkg::t_valve mask);
        logic hit;
        hit = 1'b0;
        if (z != '0 && z <= izs_pkg::t_zone'(izs_pkg::MASK_W)) begin
            hit = mask[izs_pkg::t_addr'(z - izs_pkg::t_zone'(1))];
        end
        return hit;
    endfunction

    function automatic izs_pkg::t_min f_sat_min(input izs_pkg::t_min m);
        return (m > izs_pkg::MAX_MINUTES) ? izs_pkg::MAX_MINUTES : m;
    endfunction

    // ---------------- configuration registers ----------------
    izs_pkg::t_zone     r_cfg_zone_count;
    logic               r_cfg_master_en;
    logic               r_cfg_cal_en;
    logic               r_cfg_rain;
    izs_pkg::t_valve    r_cfg_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_zone_count <= izs_pkg::t_zone'(8);
            r_cfg_master_en  <= 1'b0;
            r_cfg_cal_en     <= 1'b1;
            r_cfg_rain       <= 1'b0;
            r_cfg_mask       <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                izs_pkg::CFG_ZONE_COUNT:    r_cfg_zone_count <= i_cfg_data[izs_pkg::ZONE_W-1:0];
                izs_pkg::CFG_MASTER_ENABLE: r_cfg_master_en  <= i_cfg_data[0];
                izs_pkg::CFG_CAL_ENABLE:    r_cfg_cal_en     <= i_cfg_data[0];
                izs_pkg::CFG_RAIN_DELAY:    r_cfg_rain       <= i_cfg_data[0];
                izs_pkg::CFG_ZONE_MASK:     r_cfg_mask       <= i_cfg_data[izs_pkg::MASK_W-1:0];
                default: begin
                    // drop writes past the register list
                end
            endcase
        end
    end

    // ---------------- block state ----------------
    t_state              r_state, n_state;
    izs_pkg::t_valve     r_valve, n_valve;
    logic                r_master, n_master;
    izs_pkg::t_zone      r_zone, n_zone;
    izs_pkg::t_run_kind  r_kind, n_kind;
    izs_pkg::t_sec       r_count, n_count;
    izs_pkg::t_min       r_run_len, n_run_len;

    // captured item
    izs_pkg::t_req       r_req_type;
    logic [1:0]          r_kind_in;
    izs_pkg::t_zone      r_z;
    logic                r_on;
    izs_pkg::t_min       r_mins;
    izs_pkg::t_min       r_newrt;

    // sequencer working registers
    logic                r_acc, n_acc;
    izs_pkg::t_zone      r_scan_z, n_scan_z;
    izs_pkg::t_min       r_min, n_min;
    izs_pkg::t_zone      r_start_z, n_start_z;
    izs_pkg::t_run_kind  r_start_kind, n_start_kind;
    izs_pkg::t_alu_val   r_tmp_a, n_tmp_a;
    izs_pkg::t_alu_val   r_tmp_b, n_tmp_b;

    // output register
    logic                r_out_valid, n_out_valid;
    logic                r_out_acc;
    izs_pkg::t_valve     r_out_valve;
    logic                r_out_master;
    izs_pkg::t_zone      r_out_zone;
    izs_pkg::t_run_kind  r_out_kind;
    izs_pkg::t_sec       r_out_count;

    logic                w_accept;
    logic                w_load;

    izs_pkg::t_mem_ctl   w_mem_ctl;
    izs_pkg::t_min       w_mem_rdata;
    izs_pkg::t_alu_req   w_alu_req;
    izs_pkg::t_alu_rsp   w_alu_rsp;

    izs_pkg::t_zone      w_eff;
    logic                w_rain_go;
    logic [1:0]          e_kind_in;
    izs_pkg::t_zone      e_z;
    logic                e_on;
    logic                w_inr;
    izs_pkg::t_addr      w_zidx;
    logic                w_cur;
    izs_pkg::t_run_kind  w_kind_e;
    izs_pkg::t_min       w_newrt_sat;
    izs_pkg::t_min       w_len_sat;

    izs_rt_mem u_rt_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mem_ctl),
        .o_rdata (w_mem_rdata)
    );

    izs_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_load      = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    // effective zone count: min(zone_count, MAX_ZONES)
    assign w_eff = (r_cfg_zone_count > izs_pkg::t_zone'(izs_pkg::MAX_ZONES))
                 ? izs_pkg::t_zone'(izs_pkg::MAX_ZONES) : r_cfg_zone_count;

    // A rain event with a scheduled run in progress acts as a single-zone
    // off request on the running zone.
    assign w_rain_go = (r_kind == izs_pkg::KIND_SCHED) && (r_zone != '0);
    assign e_kind_in = (r_req_type == izs_pkg::REQ_RAIN) ? izs_pkg::RUNIN_SINGLE : r_kind_in;
    assign e_z       = (r_req_type == izs_pkg::REQ_RAIN) ? r_zone : r_z;
    assign e_on      = (r_req_type == izs_pkg::REQ_RAIN) ? 1'b0 : r_on;

    assign w_inr       = (e_z != '0) && (e_z <= w_eff);
    assign w_zidx      = izs_pkg::t_addr'(e_z - izs_pkg::t_zone'(1));
    assign w_cur       = r_valve[w_zidx];
    assign w_kind_e    = izs_pkg::t_run_kind'(e_kind_in + 2'd1);
    assign w_newrt_sat = f_sat_min(r_newrt);
    assign w_len_sat   = f_sat_min((r_mins == '0) ? w_mem_rdata : r_mins);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state      = r_state;
        n_valve      = r_valve;
        n_master     = r_master;
        n_zone       = r_zone;
        n_kind       = r_kind;
        n_count      = r_count;
        n_run_len    = r_run_len;
        n_acc        = r_acc;
        n_scan_z     = r_scan_z;
        n_min        = r_min;
        n_start_z    = r_start_z;
        n_start_kind = r_start_kind;
        n_tmp_a      = r_tmp_a;
        n_tmp_b      = r_tmp_b;

        w_mem_ctl.we    = 1'b0;
        w_mem_ctl.waddr = w_zidx;
        w_mem_ctl.wdata = w_newrt_sat;
        w_mem_ctl.raddr = '0;

        w_alu_req.op = izs_pkg::ALU_SUB;
        w_alu_req.a  = '0;
        w_alu_req.b  = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_acc   = 1'b0;
                n_state = S_DONE;
                case (r_req_type)
                    izs_pkg::REQ_TICK: begin
                        if (r_kind != izs_pkg::KIND_NONE) begin
                            n_state = S_TICK;
                        end
                    end

                    izs_pkg::REQ_RTWRITE: begin
                        if (w_inr) begin
                            w_mem_ctl.we = 1'b1;
                            n_acc        = 1'b1;
                            if (r_kind != izs_pkg::KIND_NONE && r_z == r_zone) begin
                                n_state = S_RW_A;
                            end
                        end
                    end

                    izs_pkg::REQ_ZONE,
                    izs_pkg::REQ_RAIN: begin
                        if (r_req_type == izs_pkg::REQ_RAIN && !w_rain_go) begin
                            // nothing to stop
                        end else if (e_kind_in > izs_pkg::RUNIN_SCHED) begin
                            // unknown run kind
                        end else if (w_inr && (w_cur == e_on)) begin
                            // zone already in the asked state
                        end else if (!w_inr && w_kind_e == izs_pkg::KIND_ALL &&
                                     ((e_on && r_kind == izs_pkg::KIND_ALL) ||
                                      (!e_on && r_kind != izs_pkg::KIND_ALL))) begin
                            // all-zones already in the asked state
                        end else if (w_kind_e == izs_pkg::KIND_SCHED && e_on &&
                                     (!r_cfg_cal_en || r_cfg_rain)) begin
                            // scheduled start blocked
                        end else if (w_kind_e == izs_pkg::KIND_ALL) begin
                            // stop everything, then for a start scan from the first zone
                            if (r_cfg_master_en) n_master = 1'b0;
                            n_valve   = '0;
                            n_kind    = izs_pkg::KIND_NONE;
                            n_zone    = '0;
                            n_count   = '0;
                            n_run_len = '0;
                            n_acc     = 1'b1;
                            if (e_on) begin
                                n_scan_z        = izs_pkg::t_zone'(1);
                                w_mem_ctl.raddr = '0;
                                n_state         = S_SCAN;
                            end
                        end else if (!w_inr) begin
                            // zone out of range
                        end else if (e_on) begin
                            // fetch the table default for the length check
                            w_mem_ctl.raddr = w_zidx;
                            n_state         = S_LEN;
                        end else begin
                            n_acc = 1'b1;
                            if (r_kind == izs_pkg::KIND_ALL) begin
                                n_state = S_EXPIRE;
                            end else begin
                                if (r_cfg_master_en) n_master = 1'b0;
                                n_valve   = r_valve & ~(izs_pkg::t_valve'(1) << w_zidx);
                                n_kind    = izs_pkg::KIND_NONE;
                                n_zone    = '0;
                                n_count   = '0;
                                n_run_len = '0;
                            end
                        end
                    end

                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            S_TICK: begin
                w_alu_req.op = izs_pkg::ALU_DEC;
                w_alu_req.a  = izs_pkg::t_alu_val'(r_count);
                n_count      = w_alu_req.a == '0 ? '0 : w_alu_rsp.sat;
                if (w_alu_rsp.sat == '0) begin
                    n_acc   = 1'b1;
                    n_state = S_EXPIRE;
                end else begin
                    n_acc   = 1'b0;
                    n_state = S_DONE;
                end
            end

            S_EXPIRE: begin
                if (r_kind == izs_pkg::KIND_ALL && r_zone < w_eff) begin
                    // advance to the next usable zone
                    n_valve         = '0;
                    n_scan_z        = r_zone + izs_pkg::t_zone'(1);
                    w_mem_ctl.raddr = izs_pkg::t_addr'(r_zone);
                    n_state         = S_SCAN;
                end else begin
                    if (r_cfg_master_en) n_master = 1'b0;
                    n_valve   = '0;
                    n_kind    = izs_pkg::KIND_NONE;
                    n_zone    = '0;
                    n_count   = '0;
                    n_run_len = '0;
                    n_state   = S_DONE;
                end
            end

            S_SCAN: begin
                // table data here belongs to r_scan_z
                if (r_scan_z > w_eff) begin
                    if (r_cfg_master_en) n_master = 1'b0;
                    n_kind    = izs_pkg::KIND_NONE;
                    n_zone    = '0;
                    n_count   = '0;
                    n_run_len = '0;
                    n_state   = S_DONE;
                end else if (f_has_output(r_scan_z, r_cfg_mask) && w_mem_rdata != '0) begin
                    n_min        = w_mem_rdata;
                    n_start_z    = r_scan_z;
                    n_start_kind = izs_pkg::KIND_ALL;
                    n_state      = S_START;
                end else begin
                    n_scan_z        = r_scan_z + izs_pkg::t_zone'(1);
                    w_mem_ctl.raddr = izs_pkg::t_addr'(r_scan_z);
                end
            end

            S_LEN: begin
                if (w_len_sat == '0 || !f_has_output(r_z, r_cfg_mask)) begin
                    n_acc   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_min        = w_len_sat;
                    n_start_z    = r_z;
                    n_start_kind = izs_pkg::t_run_kind'(r_kind_in + 2'd1);
                    n_state      = S_START;
                end
            end

            S_START: begin
                w_alu_req.op = izs_pkg::ALU_MUL_SPM;
                w_alu_req.a  = izs_pkg::t_alu_val'(r_min);
                n_count      = w_alu_rsp.sat;
                n_valve      = izs_pkg::t_valve'(1)
                             << izs_pkg::t_addr'(r_start_z - izs_pkg::t_zone'(1));
                if (r_cfg_master_en) n_master = 1'b1;
                n_zone       = r_start_z;
                n_run_len    = r_min;
                n_kind       = r_start_kind;
                n_acc        = 1'b1;
                n_state      = S_DONE;
            end

            // Rescale the running zone: left = new*60 - (old*60 - count)
            S_RW_A: begin
                w_alu_req.op = izs_pkg::ALU_MUL_SPM;
                w_alu_req.a  = izs_pkg::t_alu_val'(r_run_len);
                n_tmp_a      = w_alu_rsp.res;
                n_state      = S_RW_B;
            end

            S_RW_B: begin
                w_alu_req.op = izs_pkg::ALU_SUB;
                w_alu_req.a  = r_tmp_a;
                w_alu_req.b  = izs_pkg::t_alu_val'(r_count);
                n_tmp_a      = w_alu_rsp.res;
                n_state      = S_RW_C;
            end

            S_RW_C: begin
                w_alu_req.op = izs_pkg::ALU_MUL_SPM;
                w_alu_req.a  = izs_pkg::t_alu_val'(w_newrt_sat);
                n_tmp_b      = w_alu_rsp.res;
                n_state      = S_RW_D;
            end

            S_RW_D: begin
                w_alu_req.op = izs_pkg::ALU_SUB;
                w_alu_req.a  = r_tmp_b;
                w_alu_req.b  = r_tmp_a;
                n_count      = w_alu_rsp.sat;
                n_run_len    = w_newrt_sat;
                n_state      = S_DONE;
            end

            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valve     <= '0;
            r_master    <= 1'b0;
            r_zone      <= '0;
            r_kind      <= izs_pkg::KIND_NONE;
            r_count     <= '0;
            r_run_len   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valve     <= n_valve;
            r_master    <= n_master;
            r_zone      <= n_zone;
            r_kind      <= n_kind;
            r_count     <= n_count;
            r_run_len   <= n_run_len;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_type <= izs_pkg::t_req'(i_req.req_type);
            r_kind_in  <= i_req.run_kind_in;
            r_z        <= i_req.zone_number;
            r_on       <= i_req.turn_on;
            r_mins     <= i_req.run_minutes;
            r_newrt    <= i_req.new_runtime;
        end
        r_acc        <= n_acc;
        r_scan_z     <= n_scan_z;
        r_min        <= n_min;
        r_start_z    <= n_start_z;
        r_start_kind <= n_start_kind;
        r_tmp_a      <= n_tmp_a;
        r_tmp_b      <= n_tmp_b;
        if (w_load) begin
            r_out_acc    <= r_acc;
            r_out_valve  <= r_valve;
            r_out_master <= r_master;
            r_out_zone   <= r_zone;
            r_out_kind   <= r_kind;
            r_out_count  <= r_count;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.accepted     = r_out_acc;
    assign o_rsp.valve_bits   = r_out_valve;
    assign o_rsp.master_on    = r_out_master;
    assign o_rsp.active_zone  = r_out_zone;
    assign o_rsp.active_kind  = r_out_kind;
    assign o_rsp.seconds_left = r_out_count;

    // ---------------- assertions ----------------
    // At most one zone valve is ever driven
    `IZS_ASSERT_IMP(a_valve_onehot0, i_clk, i_rst_n, 1'b1, $onehot0(r_valve))
    // Between items, no run means no valve, no zone and no countdown
    `IZS_ASSERT_IMP(a_idle_no_run, i_clk, i_rst_n, (r_state == S_IDLE) && (r_kind == izs_pkg::KIND_NONE), (r_valve == '0) && (r_zone == '0) && (r_count == '0))
    // Between items, a run drives exactly the running zone's valve
    `IZS_ASSERT_IMP(a_idle_run_valve, i_clk, i_rst_n, (r_state == S_IDLE) && (r_kind != izs_pkg::KIND_NONE), (r_zone != '0) && (r_valve == (izs_pkg::t_valve'(1) << izs_pkg::t_addr'(r_zone - izs_pkg::t_zone'(1)))))
    // One item in flight: no new transaction right after one is taken
    `IZS_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !i_req.ready)

endmodule

/* rtl/izs_alu.sv */
// ----------------------------------------------------------------------------
// Irrigation zone sequencer shared arithmetic unit
// One subtractor: minutes-to-seconds, difference, or saturating decrement,
// with a clamp of the result to the valid seconds range.
// ----------------------------------------------------------------------------
module izs_alu (
    input  izs_pkg::t_alu_req i_req,
    output izs_pkg::t_alu_rsp o_rsp
);

    izs_pkg::t_alu_val w_x;
    izs_pkg::t_alu_val w_y;
    izs_pkg::t_alu_val w_d;

    always_comb begin
        case (i_req.op)
            izs_pkg::ALU_MUL_SPM: begin
                w_x = i_req.a <<< izs_pkg::SPM_SHIFT_HI;
                w_y = i_req.a <<< izs_pkg::SPM_SHIFT_LO;
            end
            izs_pkg::ALU_SUB: begin
                w_x = i_req.a;
                w_y = i_req.b;
            end
            izs_pkg::ALU_DEC: begin
                // hold at zero
                w_x = i_req.a;
                w_y = (i_req.a != '0) ? izs_pkg::t_alu_val'(1) : '0;
            end
            default: begin
                w_x = i_req.a;
                w_y = '0;
            end
        endcase
        w_d = w_x - w_y;
    end

    assign o_rsp.res = w_d;

    always_comb begin
        if (w_d < 0) begin
            o_rsp.sat = '0;
        end else if (w_d > izs_pkg::MAX_SECONDS) begin
            o_rsp.sat = izs_pkg::t_sec'(izs_pkg::MAX_SECONDS);
        end else begin
            o_rsp.sat = w_d[izs_pkg::SEC_W-1:0];
        end
    end

endmodule

/* rtl/izs_rt_mem.sv */
// ----------------------------------------------------------------------------
// Irrigation zone sequencer runtime table
// Per-zone default runtimes, one write and one registered read per cycle.
// Valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module izs_rt_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  izs_pkg::t_mem_ctl i_ctl,
    output izs_pkg::t_min     o_rdata
);

    izs_pkg::t_min              r_mem [izs_pkg::MAX_ZONES];
    logic [izs_pkg::MAX_ZONES-1:0] r_valid;
    izs_pkg::t_min              r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.we) begin
            r_valid[i_ctl.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        r_rdata <= r_valid[i_ctl.raddr] ? r_mem[i_ctl.raddr] : '0;
    end

    assign o_rdata = r_rdata;

endmodule
